// File: sv/mlrc_pkg.sv
package mlrc_pkg;

    localparam int LINES_DEF          = 8;
    localparam int LINES_PER_BANK_DEF = 4;

    // Forward-reverse pin flips after this many ticks of a burst
    localparam logic [4:0] TOGGLE_TICKS = 5'd25;
    localparam logic [4:0] TOGGLE_MAX   = 5'd31;

    localparam logic [15:0] RING_LENGTH_RESET = 16'd2000;
    localparam logic [15:0] RING_PAUSE_RESET  = 16'd4000;
    localparam logic [7:0]  RING_ITER_RESET   = 8'd5;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_RING_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RING_PAUSE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RING_ITER   = 2'd2;

    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_START    = 2'd1;
    localparam logic [1:0] CMD_STOP     = 2'd2;
    localparam logic [1:0] CMD_STOP_ALL = 2'd3;

    localparam logic PIN_FR = 1'b0;
    localparam logic PIN_RM = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_RING  = 2'd1,
        PH_PAUSE = 2'd2
    } phase_t;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_STOP = 1'b1
    } unit_op_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [2:0] line;
        logic [7:0] idle_mask;
    } cmd_item_t;

    typedef struct packed {
        logic       bank;
        logic [2:0] out_line;
        logic       pin_sel;
        logic       level;
        logic       last;
    } pin_item_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  burst_count;
        logic [15:0] phase_elapsed;
        logic [4:0]  toggle_elapsed;
        logic        fr_level;
        logic        rm_driven;
    } line_rec_t;

    typedef struct packed {
        logic [15:0] ring_length;
        logic [15:0] ring_pause;
        logic [7:0]  ring_iter;
    } ring_cfg_t;

    // Up to five pin writes one line can cause in one pass
    typedef struct packed {
        logic [2:0] count;
        logic [4:0] pin_sel;
        logic [4:0] level;
    } wr_list_t;

endpackage

// File: sv/mlrc_line_unit.sv
module mlrc_line_unit
(
    input  mlrc_pkg::line_rec_t rec,
    input  mlrc_pkg::unit_op_t  op,
    input  logic                idle,
    input  mlrc_pkg::ring_cfg_t cfg,
    output mlrc_pkg::line_rec_t rec_next,
    output mlrc_pkg::wr_list_t  writes
);

    always_comb
    begin
        mlrc_pkg::line_rec_t r;
        logic [2:0]          n;
        logic [4:0]          pins;
        logic [4:0]          lvls;

        r    = rec;
        n    = 3'd0;
        pins = '0;
        lvls = '0;

        if (rec.phase != mlrc_pkg::PH_IDLE)
        begin
            if (op == mlrc_pkg::OP_STOP || !idle)
            begin
                pins[n] = mlrc_pkg::PIN_FR; lvls[n] = 1'b0; n = n + 3'd1;
                pins[n] = mlrc_pkg::PIN_RM; lvls[n] = 1'b0; n = n + 3'd1;
                r.phase = mlrc_pkg::PH_IDLE;
            end
            else
            begin
                if (rec.phase_elapsed != 16'hFFFF)
                begin
                    r.phase_elapsed = rec.phase_elapsed + 16'd1;
                end
                if (rec.phase == mlrc_pkg::PH_RING)
                begin
                    if (!rec.rm_driven)
                    begin
                        pins[n] = mlrc_pkg::PIN_RM; lvls[n] = 1'b1; n = n + 3'd1;
                        r.rm_driven = 1'b1;
                    end
                    if (rec.toggle_elapsed < mlrc_pkg::TOGGLE_MAX)
                    begin
                        r.toggle_elapsed = rec.toggle_elapsed + 5'd1;
                    end
                    if (r.toggle_elapsed >= mlrc_pkg::TOGGLE_TICKS)
                    begin
                        r.fr_level       = ~rec.fr_level;
                        pins[n]          = mlrc_pkg::PIN_FR;
                        lvls[n]          = r.fr_level;
                        n                = n + 3'd1;
                        r.toggle_elapsed = 5'd0;
                    end
                    if (r.phase_elapsed >= cfg.ring_length)
                    begin
                        pins[n] = mlrc_pkg::PIN_FR; lvls[n] = 1'b0; n = n + 3'd1;
                        r.fr_level = 1'b0;
                        if (rec.burst_count != 8'hFF)
                        begin
                            r.burst_count = rec.burst_count + 8'd1;
                        end
                        if (r.burst_count >= cfg.ring_iter)
                        begin
                            pins[n] = mlrc_pkg::PIN_FR; lvls[n] = 1'b0; n = n + 3'd1;
                            pins[n] = mlrc_pkg::PIN_RM; lvls[n] = 1'b0; n = n + 3'd1;
                            r.phase = mlrc_pkg::PH_IDLE;
                        end
                        else
                        begin
                            r.phase         = mlrc_pkg::PH_PAUSE;
                            r.phase_elapsed = 16'd0;
                        end
                    end
                end
                else if (r.phase_elapsed >= cfg.ring_pause)
                begin
                    r.phase          = mlrc_pkg::PH_RING;
                    r.phase_elapsed  = 16'd0;
                    r.toggle_elapsed = 5'd0;
                    r.fr_level       = 1'b0;
                    r.rm_driven      = 1'b0;
                end
            end
        end

        rec_next       = r;
        writes.count   = n;
        writes.pin_sel = pins;
        writes.level   = lvls;
    end

endmodule

// File: sv/multi_line_ring_cadence.sv
// Ring cadence generator for up to LINES telephone lines. Each accepted command
// transaction yields zero or more pin-write transactions on the wr channel, the
// final one flagged by last. A start command writes no pins.
// A tick or stop-all walks every line through one shared line-update unit: each
// line is evaluated, then its pin writes are emitted, and a closing flush step
// releases the final write. A single-line stop evaluates only that line. The
// unit evaluates one line per pass and the output register issues one write per
// cycle unless wr stalls; cmd_ready is low for the whole of a walk.
// Configuration writes are taken at any time and belong between commands.
module multi_line_ring_cadence
#(
    parameter int LINES          = mlrc_pkg::LINES_DEF,
    parameter int LINES_PER_BANK = mlrc_pkg::LINES_PER_BANK_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_ready,
    input  mlrc_pkg::cmd_item_t                 cmd_item,
    output logic                                wr_valid,
    input  logic                                wr_ready,
    output mlrc_pkg::pin_item_t                 wr_item,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mlrc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mlrc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int IDX_W = (LINES > 1) ? $clog2(LINES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINES - 1);

    // Record of a freshly started line
    localparam mlrc_pkg::line_rec_t START_REC = '{
        phase:          mlrc_pkg::PH_RING,
        burst_count:    8'd0,
        phase_elapsed:  16'd0,
        toggle_elapsed: 5'd0,
        fr_level:       1'b0,
        rm_driven:      1'b0
    };

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_EMIT,
        S_FLUSH
    } state_t;

    state_t              state_reg, state_next;
    logic [1:0]          cmd_reg, cmd_next;
    logic [7:0]          mask_reg, mask_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                single_reg, single_next;
    mlrc_pkg::wr_list_t  list_reg, list_next;
    logic [2:0]          ptr_reg, ptr_next;
    logic                hold_valid_reg, hold_valid_next;
    mlrc_pkg::pin_item_t hold_reg, hold_next;
    logic                out_valid_reg, out_valid_next;
    mlrc_pkg::pin_item_t out_reg, out_next;

    mlrc_pkg::line_rec_t rec_reg [LINES];
    mlrc_pkg::ring_cfg_t cfg_reg;

    mlrc_pkg::line_rec_t unit_rec;
    mlrc_pkg::wr_list_t  unit_list;
    mlrc_pkg::unit_op_t  unit_op;
    logic                unit_idle;
    logic [3:0]          idx_w4;
    logic                cmd_accept;
    logic                start_line_ok;
    logic                start_ok;
    logic [IDX_W-1:0]    cmd_idx;
    logic                out_free;
    mlrc_pkg::pin_item_t cur_wr;

    assign cmd_ready  = (state_reg == S_IDLE);
    assign cmd_accept = cmd_valid && cmd_ready;
    assign cfg_ready  = 1'b1;
    assign wr_valid   = out_valid_reg;
    assign wr_item    = out_reg;

    assign start_line_ok = (32'(cmd_item.line) < LINES);
    assign cmd_idx       = IDX_W'(cmd_item.line);
    assign start_ok      = start_line_ok && cmd_item.idle_mask[cmd_item.line];

    // Lines past the width of the idle mask always read as busy
    assign idx_w4    = 4'(idx_reg);
    assign unit_idle = !idx_w4[3] && mask_reg[idx_w4[2:0]];
    assign unit_op   = (cmd_reg == mlrc_pkg::CMD_TICK) ? mlrc_pkg::OP_TICK
                                                       : mlrc_pkg::OP_STOP;

    mlrc_line_unit u_line_unit
    (
        .rec      (rec_reg[idx_reg]),
        .op       (unit_op),
        .idle     (unit_idle),
        .cfg      (cfg_reg),
        .rec_next (unit_rec),
        .writes   (unit_list)
    );

    assign out_free = !out_valid_reg || wr_ready;

    always_comb
    begin
        cur_wr.bank     = (32'(idx_reg) >= LINES_PER_BANK);
        cur_wr.out_line = idx_w4[2:0];
        cur_wr.pin_sel  = list_reg.pin_sel[ptr_reg];
        cur_wr.level    = list_reg.level[ptr_reg];
        cur_wr.last     = 1'b0;
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        mask_next       = mask_reg;
        idx_next        = idx_reg;
        single_next     = single_reg;
        list_next       = list_reg;
        ptr_next        = ptr_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;

        if (out_valid_reg && wr_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_accept)
                begin
                    cmd_next  = cmd_item.cmd;
                    mask_next = cmd_item.idle_mask;
                    if (cmd_item.cmd == mlrc_pkg::CMD_TICK ||
                        cmd_item.cmd == mlrc_pkg::CMD_STOP_ALL)
                    begin
                        idx_next    = '0;
                        single_next = 1'b0;
                        state_next  = S_EVAL;
                    end
                    else if (cmd_item.cmd == mlrc_pkg::CMD_STOP && start_line_ok)
                    begin
                        idx_next    = cmd_idx;
                        single_next = 1'b1;
                        state_next  = S_EVAL;
                    end
                end
            end
            S_EVAL:
            begin
                list_next  = unit_list;
                ptr_next   = 3'd0;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // Keep one write back so the final one can carry last
                if (ptr_reg < list_reg.count)
                begin
                    if (!hold_valid_reg)
                    begin
                        hold_valid_next = 1'b1;
                        hold_next       = cur_wr;
                        ptr_next        = ptr_reg + 3'd1;
                    end
                    else if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = hold_reg;
                        hold_next      = cur_wr;
                        ptr_next       = ptr_reg + 3'd1;
                    end
                end
                else if (single_reg || idx_reg == LAST_IDX)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_EVAL;
                end
            end
            S_FLUSH:
            begin
                if (!hold_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = hold_reg;
                    out_next.last   = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        mask_reg   <= mask_next;
        idx_reg    <= idx_next;
        single_reg <= single_next;
        list_reg   <= list_next;
        ptr_reg    <= ptr_next;
        hold_reg   <= hold_next;
        out_reg    <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LINES; i++)
            begin
                rec_reg[i] <= '0;
            end
        end
        else if (state_reg == S_EVAL)
        begin
            rec_reg[idx_reg] <= unit_rec;
        end
        else if (cmd_accept && cmd_item.cmd == mlrc_pkg::CMD_START && start_ok)
        begin
            rec_reg[cmd_idx] <= START_REC;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ring_length <= mlrc_pkg::RING_LENGTH_RESET;
            cfg_reg.ring_pause  <= mlrc_pkg::RING_PAUSE_RESET;
            cfg_reg.ring_iter   <= mlrc_pkg::RING_ITER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mlrc_pkg::REG_RING_LENGTH: cfg_reg.ring_length <= cfg_data;
                mlrc_pkg::REG_RING_PAUSE:  cfg_reg.ring_pause  <= cfg_data;
                mlrc_pkg::REG_RING_ITER:   cfg_reg.ring_iter   <= cfg_data[7:0];
                default:                   ;
            endcase
        end
    end

endmodule

// File: sv/mlrc_checker.sv
module mlrc_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_valid,
    input logic                cmd_ready,
    input mlrc_pkg::cmd_item_t cmd_item,
    input logic                wr_valid,
    input logic                wr_ready,
    input mlrc_pkg::pin_item_t wr_item
);

    // Hold a stalled write transaction
    a_wr_hold: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid && !wr_ready |=> wr_valid && $stable(wr_item))
        else $error("wr transaction changed while stalled");

    // A tick or stop-all always starts a walk over the lines
    a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready &&
        (cmd_item.cmd == mlrc_pkg::CMD_TICK || cmd_item.cmd == mlrc_pkg::CMD_STOP_ALL)
        |=> !cmd_ready)
        else $error("cmd_ready high right after a walk command");

    // Start writes no pins
    a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && cmd_item.cmd == mlrc_pkg::CMD_START && !wr_valid
        |=> !wr_valid)
        else $error("pin write after a start command");

    // A write that is not the last one means the command is still in progress
    a_not_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid && !wr_item.last |-> !cmd_ready)
        else $error("new command accepted before the last write was issued");

endmodule

bind multi_line_ring_cadence mlrc_checker u_mlrc_checker (.*);
